// ----- src/guidance_mode_arbiter_macros.svh -----
// assertion macros shared by the guidance mode arbiter rtl
// no dependencies; included by modules that carry assertions
`ifndef GUIDANCE_MODE_ARBITER_MACROS_SVH
`define GUIDANCE_MODE_ARBITER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GMA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gma_pkg.sv -----
// shared types, codes and reset values for the guidance mode arbiter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gma_pkg;

    localparam int AGE_W    = 16;
    localparam int CNT_W    = 8;
    localparam int MODE_W   = 2;
    localparam int RSN_W    = 4;
    localparam int STATUS_W = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int REG_IDX_W = 3;

    // leader status codes
    localparam logic [STATUS_W-1:0] STATUS_FAULT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ESTOP = 2'd2;

    // guidance modes
    localparam logic [MODE_W-1:0] MODE_HOLD      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAYPOINT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VISION    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EMERGENCY = 2'd3;

    // reason codes
    localparam logic [RSN_W-1:0] RSN_NONE        = 4'd0;
    localparam logic [RSN_W-1:0] RSN_INIT        = 4'd1;
    localparam logic [RSN_W-1:0] RSN_ESTOP       = 4'd2;
    localparam logic [RSN_W-1:0] RSN_FAULT       = 4'd3;
    localparam logic [RSN_W-1:0] RSN_WP_TIMEOUT  = 4'd4;
    localparam logic [RSN_W-1:0] RSN_BOTH_LOST   = 4'd5;
    localparam logic [RSN_W-1:0] RSN_WP_BACK     = 4'd6;
    localparam logic [RSN_W-1:0] RSN_VIS_TIMEOUT = 4'd7;
    localparam logic [RSN_W-1:0] RSN_VIS_BACK    = 4'd8;
    localparam logic [RSN_W-1:0] RSN_TRANSITION  = 4'd9;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WP_TIMEOUT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VIS_TIMEOUT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WP_OK       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WP_LOST     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VIS_OK      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_VIS_LOST    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LATCH_STOP  = 3'd6;

    // register reset values
    localparam logic [AGE_W-1:0] RST_WP_TIMEOUT  = 16'd400;
    localparam logic [AGE_W-1:0] RST_VIS_TIMEOUT = 16'd200;
    localparam logic [CNT_W-1:0] RST_WP_OK       = 8'd5;
    localparam logic [CNT_W-1:0] RST_WP_LOST     = 8'd3;
    localparam logic [CNT_W-1:0] RST_VIS_OK      = 8'd3;
    localparam logic [CNT_W-1:0] RST_VIS_LOST    = 8'd3;
    localparam logic             RST_LATCH_STOP  = 1'b1;

    typedef struct packed {
        logic [AGE_W-1:0] waypoint_timeout_ms;
        logic [AGE_W-1:0] vision_timeout_ms;
        logic [CNT_W-1:0] waypoint_ok_needed;
        logic [CNT_W-1:0] waypoint_lost_needed;
        logic [CNT_W-1:0] vision_ok_needed;
        logic [CNT_W-1:0] vision_lost_needed;
        logic             latch_stop;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] leader_status;
        logic                waypoint_valid;
        logic [AGE_W-1:0]    waypoint_age_ms;
        logic                vision_valid;
        logic [AGE_W-1:0]    vision_age_ms;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0] mode_out;
        logic [RSN_W-1:0]  reason_code;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/gma_if.sv -----
// valid/ready channel interfaces for arbiter input and result transactions
// depends on gma_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gma_item_if import gma_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] leader_status;
    logic                waypoint_valid;
    logic [AGE_W-1:0]    waypoint_age_ms;
    logic                vision_valid;
    logic [AGE_W-1:0]    vision_age_ms;

    modport source (
        output valid, leader_status, waypoint_valid, waypoint_age_ms,
               vision_valid, vision_age_ms,
        input  ready
    );
    modport sink (
        input  valid, leader_status, waypoint_valid, waypoint_age_ms,
               vision_valid, vision_age_ms,
        output ready
    );
endinterface

interface gma_result_if import gma_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode_out;
    logic [RSN_W-1:0]  reason_code;

    modport source (output valid, mode_out, reason_code, input ready);
    modport sink (input valid, mode_out, reason_code, output ready);
endinterface

`default_nettype wire

// ----- src/gma_cfg.sv -----
// apb register file holding the arbiter timeouts, thresholds and latch enable
// depends on gma_pkg
`timescale 1ns / 1ps
`default_nettype none

module gma_cfg import gma_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waypoint_timeout_ms  <= RST_WP_TIMEOUT;
            r_cfg.vision_timeout_ms    <= RST_VIS_TIMEOUT;
            r_cfg.waypoint_ok_needed   <= RST_WP_OK;
            r_cfg.waypoint_lost_needed <= RST_WP_LOST;
            r_cfg.vision_ok_needed     <= RST_VIS_OK;
            r_cfg.vision_lost_needed   <= RST_VIS_LOST;
            r_cfg.latch_stop           <= RST_LATCH_STOP;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WP_TIMEOUT:  r_cfg.waypoint_timeout_ms  <= pwdata[AGE_W-1:0];
                REG_VIS_TIMEOUT: r_cfg.vision_timeout_ms    <= pwdata[AGE_W-1:0];
                REG_WP_OK:       r_cfg.waypoint_ok_needed   <= pwdata[CNT_W-1:0];
                REG_WP_LOST:     r_cfg.waypoint_lost_needed <= pwdata[CNT_W-1:0];
                REG_VIS_OK:      r_cfg.vision_ok_needed     <= pwdata[CNT_W-1:0];
                REG_VIS_LOST:    r_cfg.vision_lost_needed   <= pwdata[CNT_W-1:0];
                REG_LATCH_STOP:  r_cfg.latch_stop           <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_WP_TIMEOUT:  prdata[AGE_W-1:0] = r_cfg.waypoint_timeout_ms;
            REG_VIS_TIMEOUT: prdata[AGE_W-1:0] = r_cfg.vision_timeout_ms;
            REG_WP_OK:       prdata[CNT_W-1:0] = r_cfg.waypoint_ok_needed;
            REG_WP_LOST:     prdata[CNT_W-1:0] = r_cfg.waypoint_lost_needed;
            REG_VIS_OK:      prdata[CNT_W-1:0] = r_cfg.vision_ok_needed;
            REG_VIS_LOST:    prdata[CNT_W-1:0] = r_cfg.vision_lost_needed;
            REG_LATCH_STOP:  prdata[0]         = r_cfg.latch_stop;
            default:         prdata            = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/gma_core.sv -----
// mode state, hysteresis counters and the per-transaction mode decision
// depends on gma_pkg and guidance_mode_arbiter_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "guidance_mode_arbiter_macros.svh"

module gma_core import gma_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_update,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [MODE_W-1:0] r_mode, n_mode;
    logic              r_started;
    logic              r_stop_latched, n_stop_latched;
    logic [CNT_W-1:0]  r_wp_ok, n_wp_ok;
    logic [CNT_W-1:0]  r_wp_lost, n_wp_lost;
    logic [CNT_W-1:0]  r_vis_ok, n_vis_ok;
    logic [CNT_W-1:0]  r_vis_lost, n_vis_lost;

    logic              wpt_fresh, vis_fresh;
    logic              wp_good, wp_bad, vis_good, vis_bad;
    logic [MODE_W-1:0] prev_mode, next_mode;
    logic [RSN_W-1:0]  reason;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] ceil);
        return (v < ceil) ? v + 1'b1 : ceil;
    endfunction

    function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] v);
        return (v != '0) ? v - 1'b1 : '0;
    endfunction

    assign wpt_fresh = i_item.waypoint_valid &&
                       (i_item.waypoint_age_ms <= i_cfg.waypoint_timeout_ms);
    assign vis_fresh = i_item.vision_valid &&
                       (i_item.vision_age_ms <= i_cfg.vision_timeout_ms);

    // counter updates, only kept on the normal path
    always_comb begin
        if (wpt_fresh) begin
            n_wp_ok   = count_up(r_wp_ok, i_cfg.waypoint_ok_needed);
            n_wp_lost = count_down(r_wp_lost);
        end else begin
            n_wp_lost = count_up(r_wp_lost, i_cfg.waypoint_lost_needed);
            n_wp_ok   = count_down(r_wp_ok);
        end
        if (vis_fresh) begin
            n_vis_ok   = count_up(r_vis_ok, i_cfg.vision_ok_needed);
            n_vis_lost = count_down(r_vis_lost);
        end else begin
            n_vis_lost = count_up(r_vis_lost, i_cfg.vision_lost_needed);
            n_vis_ok   = count_down(r_vis_ok);
        end
    end

    assign wp_good  = n_wp_ok >= i_cfg.waypoint_ok_needed;
    assign wp_bad   = n_wp_lost >= i_cfg.waypoint_lost_needed;
    assign vis_good = n_vis_ok >= i_cfg.vision_ok_needed;
    assign vis_bad  = n_vis_lost >= i_cfg.vision_lost_needed;

    always_comb begin
        prev_mode      = r_started ? r_mode : MODE_HOLD;
        reason         = r_started ? RSN_NONE : RSN_INIT;
        next_mode      = prev_mode;
        n_stop_latched = r_stop_latched;
        n_mode         = prev_mode;

        if (i_item.leader_status == STATUS_ESTOP) begin
            if (i_cfg.latch_stop) begin
                n_stop_latched = 1'b1;
            end
            n_mode = MODE_EMERGENCY;
            reason = RSN_ESTOP;
        end else if (i_item.leader_status == STATUS_FAULT) begin
            n_mode = MODE_HOLD;
            reason = RSN_FAULT;
        end else if (r_stop_latched) begin
            n_mode = MODE_EMERGENCY;
            reason = RSN_ESTOP;
        end else begin
            case (prev_mode)
                MODE_WAYPOINT: begin
                    if (wp_bad) begin
                        if (vis_good) begin
                            next_mode = MODE_VISION;
                            reason    = RSN_WP_TIMEOUT;
                        end else begin
                            next_mode = MODE_HOLD;
                            reason    = RSN_BOTH_LOST;
                        end
                    end
                end
                MODE_VISION: begin
                    if (wp_good) begin
                        next_mode = MODE_WAYPOINT;
                        reason    = RSN_WP_BACK;
                    end else if (vis_bad) begin
                        next_mode = MODE_HOLD;
                        reason    = RSN_VIS_TIMEOUT;
                    end
                end
                MODE_HOLD: begin
                    if (wp_good) begin
                        next_mode = MODE_WAYPOINT;
                        reason    = RSN_WP_BACK;
                    end else if (vis_good) begin
                        next_mode = MODE_VISION;
                        reason    = RSN_VIS_BACK;
                    end else if (wp_bad && vis_bad) begin
                        reason = RSN_BOTH_LOST;
                    end
                end
                default: ;
            endcase

            // guard: a follow mode never survives a stale source in this transaction
            n_mode = next_mode;
            if (next_mode == MODE_WAYPOINT && !wpt_fresh) begin
                n_mode = vis_fresh ? MODE_VISION : MODE_HOLD;
            end else if (next_mode == MODE_VISION && !vis_fresh) begin
                n_mode = wpt_fresh ? MODE_WAYPOINT : MODE_HOLD;
            end

            if (n_mode != prev_mode && reason == RSN_NONE) begin
                reason = RSN_TRANSITION;
            end
        end
    end

    assign o_result.mode_out    = n_mode;
    assign o_result.reason_code = reason;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_HOLD;
            r_started      <= 1'b0;
            r_stop_latched <= 1'b0;
            r_wp_ok        <= '0;
            r_wp_lost      <= '0;
            r_vis_ok       <= '0;
            r_vis_lost     <= '0;
        end else if (i_update) begin
            r_mode         <= n_mode;
            r_started      <= 1'b1;
            r_stop_latched <= n_stop_latched;
            // leader stop, fault or a latched stop freeze the counters
            if (i_item.leader_status != STATUS_ESTOP &&
                i_item.leader_status != STATUS_FAULT && !r_stop_latched) begin
                r_wp_ok    <= n_wp_ok;
                r_wp_lost  <= n_wp_lost;
                r_vis_ok   <= n_vis_ok;
                r_vis_lost <= n_vis_lost;
            end
        end
    end

    `GMA_ASSERT_NEXT(a_latch_sticks, i_clk, i_rst_n, r_stop_latched, r_stop_latched, "stop latch cleared")
    `GMA_ASSERT_NEXT(a_update_starts, i_clk, i_rst_n, i_update, r_started, "started flag not set after a transaction")
    `GMA_ASSERT_IMPLIES(a_idle_before_start, i_clk, i_rst_n, !r_started, (r_mode == MODE_HOLD) && !r_stop_latched, "state moved before the first transaction")

endmodule

`default_nettype wire

// ----- src/guidance_mode_arbiter.sv -----
// guidance mode arbiter top level: input stage, decision core, result register
// depends on gma_pkg, gma_if, gma_cfg, gma_core and guidance_mode_arbiter_macros.svh
//
// usage:
//  - i_item (valid/ready) carries one transaction per message: leader status and
//    validity and age of the waypoint and vision sources
//  - o_result (valid/ready) returns exactly one transaction per input: the new
//    guidance mode and a reason code; the first transaction after reset reports
//    init unless a stronger reason takes over
//  - apb port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the two
//    timeouts, four hysteresis thresholds and the stop latch enable at byte
//    addresses 0, 4 .. 24; write it only while no transaction is in flight
//  - path: a taken input passes the input stage register, then the result register
//  - throughput: one transaction per cycle unless o_result stalls; the whole
//    decision is one pass of logic between the input stage and result registers
//  - reset (synchronous, active low): registers return to defaults, mode is
//    hold, counters and stop latch clear, both channels empty
//  - receiver stall: the result register holds and the input stage still takes
//    one more transaction; i_item.ready drops only when both are full
`timescale 1ns / 1ps
`default_nettype none
`include "guidance_mode_arbiter_macros.svh"

module guidance_mode_arbiter import gma_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gma_item_if.sink               i_item,
    gma_result_if.source           o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg      cfg;
    t_in_item  r_stage;
    logic      r_stage_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item core_result;
    logic      advance;
    logic      take_in;

    gma_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage moves into the result register when that register is free or draining
    assign advance        = r_stage_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_stage_valid || advance;
    assign take_in        = i_item.valid && i_item.ready;

    gma_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_item   (r_stage),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (take_in) begin
            r_stage_valid <= 1'b1;
        end else if (advance) begin
            r_stage_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_stage.leader_status   <= i_item.leader_status;
            r_stage.waypoint_valid  <= i_item.waypoint_valid;
            r_stage.waypoint_age_ms <= i_item.waypoint_age_ms;
            r_stage.vision_valid    <= i_item.vision_valid;
            r_stage.vision_age_ms   <= i_item.vision_age_ms;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.mode_out    = r_out.mode_out;
    assign o_result.reason_code = r_out.reason_code;

    `GMA_ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, !i_item.ready, r_stage_valid && r_out_valid, "input stalled with a free stage")
    `GMA_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, r_out_valid, "result register empty after a stage advance")

endmodule

`default_nettype wire

// ----- verif/gma_arbiter_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the guidance mode arbiter: watches the item, result and apb write traffic
// and checks every result against its own copy of the mode logic
// depends on gma_pkg and gma_if
module gma_arbiter_checker import gma_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gma_item_if               i_item,
    gma_result_if             i_result,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output int                o_error_count,
    output int                o_pending,
    output int                o_checked
);

    t_cfg              regs;
    logic [MODE_W-1:0] mode_q;
    logic              started;
    logic              stop_latched;
    logic [CNT_W-1:0]  wpt_ok_cnt, wpt_lost_cnt, vis_ok_cnt, vis_lost_cnt;
    t_out_item         expected_modes[$];
    int                errors = 0;
    int                checked = 0;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] limit);
        return (v < limit) ? v + 1'b1 : limit;
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
        return (v != '0) ? v - 1'b1 : '0;
    endfunction

    task automatic write_shadow(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
        case (idx)
            REG_WP_TIMEOUT:  regs.waypoint_timeout_ms  = data[AGE_W-1:0];
            REG_VIS_TIMEOUT: regs.vision_timeout_ms    = data[AGE_W-1:0];
            REG_WP_OK:       regs.waypoint_ok_needed   = data[CNT_W-1:0];
            REG_WP_LOST:     regs.waypoint_lost_needed = data[CNT_W-1:0];
            REG_VIS_OK:      regs.vision_ok_needed     = data[CNT_W-1:0];
            REG_VIS_LOST:    regs.vision_lost_needed   = data[CNT_W-1:0];
            REG_LATCH_STOP:  regs.latch_stop           = data[0];
            default: ;
        endcase
    endtask

    // one decision step: updates the shadow state and gives the mode and reason
    task automatic advance_arbiter(input t_in_item itm, output t_out_item res);
        logic [RSN_W-1:0]  rsn;
        logic [MODE_W-1:0] prev_mode, next_mode;
        logic              wpt_fresh, vis_fresh, wp_good, wp_bad, vis_good, vis_bad;
        if (!started) begin
            started = 1'b1;
            mode_q  = MODE_HOLD;
            rsn     = RSN_INIT;
        end else begin
            rsn = RSN_NONE;
        end

        if (itm.leader_status == STATUS_ESTOP) begin
            if (regs.latch_stop) stop_latched = 1'b1;
            mode_q = MODE_EMERGENCY;
            rsn    = RSN_ESTOP;
        end else if (itm.leader_status == STATUS_FAULT) begin
            mode_q = MODE_HOLD;
            rsn    = RSN_FAULT;
        end else if (stop_latched) begin
            mode_q = MODE_EMERGENCY;
            rsn    = RSN_ESTOP;
        end else begin
            wpt_fresh = itm.waypoint_valid && (itm.waypoint_age_ms <= regs.waypoint_timeout_ms);
            vis_fresh = itm.vision_valid && (itm.vision_age_ms <= regs.vision_timeout_ms);

            if (wpt_fresh) begin
                wpt_ok_cnt   = sat_inc(wpt_ok_cnt, regs.waypoint_ok_needed);
                wpt_lost_cnt = sat_dec(wpt_lost_cnt);
            end else begin
                wpt_lost_cnt = sat_inc(wpt_lost_cnt, regs.waypoint_lost_needed);
                wpt_ok_cnt   = sat_dec(wpt_ok_cnt);
            end
            if (vis_fresh) begin
                vis_ok_cnt   = sat_inc(vis_ok_cnt, regs.vision_ok_needed);
                vis_lost_cnt = sat_dec(vis_lost_cnt);
            end else begin
                vis_lost_cnt = sat_inc(vis_lost_cnt, regs.vision_lost_needed);
                vis_ok_cnt   = sat_dec(vis_ok_cnt);
            end
            wp_good  = wpt_ok_cnt >= regs.waypoint_ok_needed;
            wp_bad   = wpt_lost_cnt >= regs.waypoint_lost_needed;
            vis_good = vis_ok_cnt >= regs.vision_ok_needed;
            vis_bad  = vis_lost_cnt >= regs.vision_lost_needed;

            prev_mode = mode_q;
            next_mode = prev_mode;
            case (prev_mode)
                MODE_WAYPOINT: begin
                    if (wp_bad) begin
                        next_mode = vis_good ? MODE_VISION : MODE_HOLD;
                        rsn       = vis_good ? RSN_WP_TIMEOUT : RSN_BOTH_LOST;
                    end
                end
                MODE_VISION: begin
                    if (wp_good) begin
                        next_mode = MODE_WAYPOINT;
                        rsn       = RSN_WP_BACK;
                    end else if (vis_bad) begin
                        next_mode = MODE_HOLD;
                        rsn       = RSN_VIS_TIMEOUT;
                    end
                end
                MODE_HOLD: begin
                    if (wp_good) begin
                        next_mode = MODE_WAYPOINT;
                        rsn       = RSN_WP_BACK;
                    end else if (vis_good) begin
                        next_mode = MODE_VISION;
                        rsn       = RSN_VIS_BACK;
                    end else if (wp_bad && vis_bad) begin
                        rsn = RSN_BOTH_LOST;
                    end
                end
                default: ;
            endcase

            // guard: a follow mode never survives a stale source in this item
            if (next_mode == MODE_WAYPOINT && !wpt_fresh)
                next_mode = vis_fresh ? MODE_VISION : MODE_HOLD;
            else if (next_mode == MODE_VISION && !vis_fresh)
                next_mode = wpt_fresh ? MODE_WAYPOINT : MODE_HOLD;

            if (next_mode != prev_mode && rsn == RSN_NONE) rsn = RSN_TRANSITION;
            mode_q = next_mode;
        end

        res.mode_out    = mode_q;
        res.reason_code = rsn;
    endtask

    task automatic flag_error();
        errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_in_item  itm;
        t_out_item pred;
        t_out_item want;
        if (!i_rst_n) begin
            regs.waypoint_timeout_ms  = RST_WP_TIMEOUT;
            regs.vision_timeout_ms    = RST_VIS_TIMEOUT;
            regs.waypoint_ok_needed   = RST_WP_OK;
            regs.waypoint_lost_needed = RST_WP_LOST;
            regs.vision_ok_needed     = RST_VIS_OK;
            regs.vision_lost_needed   = RST_VIS_LOST;
            regs.latch_stop           = RST_LATCH_STOP;
            mode_q       = MODE_HOLD;
            started      = 1'b0;
            stop_latched = 1'b0;
            wpt_ok_cnt   = '0;
            wpt_lost_cnt = '0;
            vis_ok_cnt   = '0;
            vis_lost_cnt = '0;
            expected_modes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_shadow(i_paddr[APB_AW-1:2], i_pwdata);

            if (i_result.valid && i_result.ready) begin
                if (expected_modes.size() == 0) begin
                    flag_error();
                    $display("%0t: result with nothing expected, expected none got mode %0d reason %0d",
                             $time, i_result.mode_out, i_result.reason_code);
                end else begin
                    want = expected_modes.pop_front();
                    checked++;
                    if (i_result.mode_out !== want.mode_out) begin
                        flag_error();
                        $display("%0t: mode mismatch, expected %0d got %0d",
                                 $time, want.mode_out, i_result.mode_out);
                    end
                    if (i_result.reason_code !== want.reason_code) begin
                        flag_error();
                        $display("%0t: reason mismatch, expected %0d got %0d",
                                 $time, want.reason_code, i_result.reason_code);
                    end
                end
            end

            if (i_item.valid && i_item.ready) begin
                itm.leader_status   = i_item.leader_status;
                itm.waypoint_valid  = i_item.waypoint_valid;
                itm.waypoint_age_ms = i_item.waypoint_age_ms;
                itm.vision_valid    = i_item.vision_valid;
                itm.vision_age_ms   = i_item.vision_age_ms;
                advance_arbiter(itm, pred);
                expected_modes.push_back(pred);
            end
        end
        o_pending     <= expected_modes.size();
        o_error_count <= errors;
        o_checked     <= checked;
    end

endmodule

// ----- verif/guidance_mode_arbiter_tb.sv -----
`timescale 1ns / 1ps
// top of the guidance mode arbiter testbench: clock, reset, apb setup, item stimulus and
// result back-pressure; the checker beside the block predicts and compares
// depends on gma_pkg, gma_if, guidance_mode_arbiter and gma_arbiter_checker
module guidance_mode_arbiter_tb;
    import gma_pkg::*;

    // leader status values that the block decodes as normal
    localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SPARE  = 2'd3;
    localparam logic [AGE_W-1:0]    AGE_MAX       = 16'hFFFF;
    localparam int HOLD_OFF_CYCLES = 80;     // long receiver stall to fill the block
    localparam int DRAIN_CYCLES    = 6;      // margin after the last result has drained

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    gma_item_if   item_bus ();
    gma_result_if result_bus ();

    int error_count, pending, checked;

    // stimulus state: timeouts last written, source freshness runs, sender bursts
    logic [AGE_W-1:0] wp_timeout_now  = RST_WP_TIMEOUT;
    logic [AGE_W-1:0] vis_timeout_now = RST_VIS_TIMEOUT;
    logic             wpt_fresh_run   = 1'b1;
    logic             vis_fresh_run   = 1'b1;
    int               wp_run_left     = 0;
    int               vis_run_left    = 0;
    int               burst_left      = 0;
    int               estop_pct       = 0;
    int               items_sent      = 0;
    int               settings_used   = 1;
    int               hold_count      = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    guidance_mode_arbiter u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gma_arbiter_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_item        (item_bus),
        .i_result      (result_bus),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_error_count (error_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // offer one transaction; the sender runs in bursts with random gaps between them
    task automatic offer_item(input t_in_item itm);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(4);
            if (gap > 0) begin
                @(negedge clk);
                item_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
        end
        burst_left--;
        @(negedge clk);
        item_bus.valid           <= 1'b1;
        item_bus.leader_status   <= itm.leader_status;
        item_bus.waypoint_valid  <= itm.waypoint_valid;
        item_bus.waypoint_age_ms <= itm.waypoint_age_ms;
        item_bus.vision_valid    <= itm.vision_valid;
        item_bus.vision_age_ms   <= itm.vision_age_ms;
        do @(posedge clk); while (item_bus.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic offer_fields(input logic [STATUS_W-1:0] status, input logic wpt_valid,
                                input logic [AGE_W-1:0] wp_age, input logic vis_valid,
                                input logic [AGE_W-1:0] vis_age);
        t_in_item itm;
        itm.leader_status   = status;
        itm.waypoint_valid  = wpt_valid;
        itm.waypoint_age_ms = wp_age;
        itm.vision_valid    = vis_valid;
        itm.vision_age_ms   = vis_age;
        offer_item(itm);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic wait_idle();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input logic [AGE_W-1:0] wp_to, input logic [AGE_W-1:0] vis_to,
                                 input logic [CNT_W-1:0] wp_ok, input logic [CNT_W-1:0] wp_lost,
                                 input logic [CNT_W-1:0] vis_ok, input logic [CNT_W-1:0] vis_lost,
                                 input logic latch);
        write_reg(REG_WP_TIMEOUT, APB_DW'(wp_to));
        write_reg(REG_VIS_TIMEOUT, APB_DW'(vis_to));
        write_reg(REG_WP_OK, APB_DW'(wp_ok));
        write_reg(REG_WP_LOST, APB_DW'(wp_lost));
        write_reg(REG_VIS_OK, APB_DW'(vis_ok));
        write_reg(REG_VIS_LOST, APB_DW'(vis_lost));
        write_reg(REG_LATCH_STOP, APB_DW'(latch));
        wp_timeout_now  = wp_to;
        vis_timeout_now = vis_to;
        settings_used++;
    endtask

    // one source: runs of fresh or stale data so the hysteresis counters get somewhere
    task automatic sample_source(inout logic fresh_run, inout int run_left,
                                 input logic [AGE_W-1:0] limit,
                                 output logic valid, output logic [AGE_W-1:0] age);
        if (run_left == 0) begin
            fresh_run = ($urandom_range(99) < 65);
            run_left  = $urandom_range(14, 1);
        end
        run_left--;
        if (fresh_run) begin
            valid = 1'b1;
            age   = ($urandom_range(7) == 0) ? limit : AGE_W'($urandom_range(limit, 0));
        end else if (limit == AGE_MAX || $urandom_range(1) == 0) begin
            valid = 1'b0;
            age   = AGE_W'($urandom_range(AGE_MAX));
        end else begin
            valid = 1'b1;
            age   = ($urandom_range(7) == 0) ? limit + 1'b1
                                             : AGE_W'($urandom_range(AGE_MAX, limit + 1));
        end
    endtask

    task automatic build_item(output t_in_item itm);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // noise: every field fully random
            itm.leader_status   = STATUS_W'($urandom_range(3));
            itm.waypoint_valid  = 1'($urandom_range(1));
            itm.waypoint_age_ms = AGE_W'($urandom_range(AGE_MAX));
            itm.vision_valid    = 1'($urandom_range(1));
            itm.vision_age_ms   = AGE_W'($urandom_range(AGE_MAX));
        end else begin
            if (pick < 8 + estop_pct)
                itm.leader_status = STATUS_ESTOP;
            else if (pick < 13 + estop_pct)
                itm.leader_status = STATUS_FAULT;
            else
                itm.leader_status = $urandom_range(1) ? STATUS_NORMAL : STATUS_SPARE;
            sample_source(wpt_fresh_run, wp_run_left, wp_timeout_now,
                          itm.waypoint_valid, itm.waypoint_age_ms);
            sample_source(vis_fresh_run, vis_run_left, vis_timeout_now,
                          itm.vision_valid, itm.vision_age_ms);
        end
    endtask

    task automatic random_phase(input int count);
        t_in_item itm;
        repeat (count) begin
            build_item(itm);
            offer_item(itm);
        end
    endtask

    // receiver: ready pattern switches between random stall rates; a hold request
    // drops ready for a long stretch while the sender keeps offering
    initial begin : result_sink
        int stall_pct;
        int mode_left;
        int holds_done;
        stall_pct  = 0;
        mode_left  = 0;
        holds_done = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_count != holds_done) begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                holds_done++;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                    mode_left = $urandom_range(60, 5);
                end
                mode_left--;
                result_bus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        item_bus.valid           <= 1'b0;
        item_bus.leader_status   <= STATUS_NORMAL;
        item_bus.waypoint_valid  <= 1'b0;
        item_bus.waypoint_age_ms <= '0;
        item_bus.vision_valid    <= 1'b0;
        item_bus.vision_age_ms   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n   <= 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings; the first transaction reports init, ages at the exact timeouts
        offer_fields(STATUS_NORMAL, 1'b1, 16'd400, 1'b1, 16'd200);
        offer_fields(STATUS_SPARE, 1'b1, 16'd0, 1'b1, 16'd0);
        offer_fields(STATUS_NORMAL, 1'b1, 16'd400, 1'b1, 16'd201);
        offer_fields(STATUS_NORMAL, 1'b1, 16'd1, 1'b1, 16'd0);
        // fault freezes the counters
        offer_fields(STATUS_FAULT, 1'b1, 16'd0, 1'b1, 16'd0);
        offer_fields(STATUS_NORMAL, 1'b1, 16'd10, 1'b1, 16'd10);
        offer_fields(STATUS_NORMAL, 1'b1, 16'd10, 1'b1, 16'd10);
        offer_fields(STATUS_SPARE, 1'b1, 16'd10, 1'b1, 16'd10);
        offer_fields(STATUS_NORMAL, 1'b1, 16'd10, 1'b1, 16'd10);
        // waypoint just past its timeout: guard hands over to vision
        offer_fields(STATUS_NORMAL, 1'b1, 16'd401, 1'b1, 16'd5);
        offer_fields(STATUS_NORMAL, 1'b0, 16'd0, 1'b1, 16'd5);
        offer_fields(STATUS_NORMAL, 1'b0, 16'd0, 1'b1, 16'd5);
        offer_fields(STATUS_NORMAL, 1'b0, AGE_MAX, 1'b1, 16'd5);
        // both sources gone
        offer_fields(STATUS_NORMAL, 1'b0, AGE_MAX, 1'b1, AGE_MAX);
        offer_fields(STATUS_NORMAL, 1'b0, 16'd0, 1'b0, 16'd0);
        offer_fields(STATUS_NORMAL, 1'b1, AGE_MAX, 1'b0, AGE_MAX);
        offer_fields(STATUS_NORMAL, 1'b0, 16'd0, 1'b0, 16'd0);
        // vision recovers alone
        offer_fields(STATUS_NORMAL, 1'b0, 16'd0, 1'b1, 16'd0);
        offer_fields(STATUS_SPARE, 1'b0, 16'd0, 1'b1, 16'd200);
        offer_fields(STATUS_NORMAL, 1'b0, 16'd0, 1'b1, 16'd100);
        offer_fields(STATUS_FAULT, 1'b1, AGE_MAX, 1'b1, AGE_MAX);
        wait_idle();

        // stop not latched: estop mode sticks until a fault
        apply_setting(16'd400, 16'd200, 8'd5, 8'd3, 8'd3, 8'd3, 1'b0);
        offer_fields(STATUS_ESTOP, 1'b1, 16'd0, 1'b1, 16'd0);
        offer_fields(STATUS_NORMAL, 1'b1, 16'd0, 1'b1, 16'd0);
        offer_fields(STATUS_FAULT, 1'b1, 16'd0, 1'b1, 16'd0);
        offer_fields(STATUS_NORMAL, 1'b1, 16'd0, 1'b1, 16'd0);
        estop_pct = 4;
        random_phase(160);
        wait_idle();

        // zero timeouts and thresholds: a source is good or bad at once
        apply_setting(16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        random_phase(130);
        wait_idle();

        // widest timeouts and highest ceilings
        apply_setting(AGE_MAX, AGE_MAX, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        random_phase(110);
        wait_idle();

        // ceilings dropped below the counters; the long receiver hold fills the block
        apply_setting(16'd1000, 16'd500, 8'd2, 8'd1, 8'd1, 8'd2, 1'b0);
        hold_count++;
        random_phase(160);
        wait_idle();

        repeat (2) begin
            apply_setting(AGE_W'($urandom_range(AGE_MAX)), AGE_W'($urandom_range(AGE_MAX)),
                          CNT_W'($urandom_range(8)), CNT_W'($urandom_range(8)),
                          CNT_W'($urandom_range(8)), CNT_W'($urandom_range(8)), 1'b0);
            random_phase(170);
            wait_idle();
        end

        // stop latch enabled last: once latched the block stays in emergency stop except on fault items
        apply_setting(16'd400, 16'd200, 8'd5, 8'd3, 8'd3, 8'd3, 1'b1);
        estop_pct = 2;
        random_phase(130);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d transactions over %0d register settings, with a long receiver hold",
                 items_sent, settings_used);
        $display("%0d results checked, %0d mismatches", checked, error_count);
        if (error_count == 0 && pending == 0) begin
            $display("[guidance_mode_arbiter] OK");
        end else begin
            $display("[guidance_mode_arbiter] ERROR");
        end
        $finish;
    end

    // run limit: far above the slowest correct run
    initial begin : watchdog
        #3_000_000;
        $display("[guidance_mode_arbiter] ERROR");
        $finish;
    end

endmodule
